FILE: rtl/core/stc_pkg.sv
// Shared types and constants for the alternating three-point stencil core.
// No dependencies; imported by stc_seq, stc_out and the top level.
package stc_pkg;

  localparam int SIDE_W       = 13;
  localparam int SAMPLE_W     = 16;
  localparam int POS_OUT_W    = 12;
  localparam int DEF_MAX_SIDE = 4096;
  localparam int SIDE_CAP     = 8191;   // largest side the 13-bit register can hold

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_ODD    = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 13'd4096;
  localparam logic              PASS_RESET = 1'b1;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x < 2**19
  localparam int SUM_W      = SAMPLE_W + 2;
  localparam int DIV3_SHIFT = 19;
  localparam logic [17:0] DIV3_MUL = 18'd174763;
  localparam int PROD_W     = SUM_W + 18;

  localparam int OUT_DATA_W = SAMPLE_W + 2 * POS_OUT_W;

  typedef struct packed {
    logic                 emit;
    logic                 avg;
    logic                 odd;
    logic                 own_sample;
    logic [SAMPLE_W-1:0]  sample;
    logic [SAMPLE_W-1:0]  last;
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 frame_end;
  } stc_ctl_t;

endpackage

FILE: rtl/core/stc_line_mem.sv
// Sample delay line: one write port, two registered read ports.
// Depends on nothing; read data is the old entry on a same-cycle write.
module stc_line_mem #(
  parameter int DEPTH  = 4097,
  parameter int AW     = 13,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/stc_seq.sv
// Stream sequencer: pending count, write slot, emit position, line addresses.
// Depends on stc_pkg; registers the per-transaction control word for stc_out.
module stc_seq import stc_pkg::*; #(
  parameter  int MAX_SIDE = DEF_MAX_SIDE,
  localparam int DEPTH    = MAX_SIDE + 1,
  localparam int AW       = $clog2(MAX_SIDE + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                adv,
  input  logic                action,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SIDE_W-1:0]   side_length,
  input  logic                pass_odd,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [SAMPLE_W-1:0] mem_wdata,
  output logic [AW-1:0]       raddr_a,
  output logic [AW-1:0]       raddr_b,
  output logic                s1_valid,
  output stc_ctl_t            s1_ctl
);

  localparam int CW   = $clog2(MAX_SIDE + 2);
  localparam int IW   = CW + 1;
  localparam int NMAX = (MAX_SIDE < SIDE_CAP) ? MAX_SIDE : SIDE_CAP;
  localparam int PW   = $clog2(NMAX + 1);
  localparam int XW   = (CW > SIDE_W) ? CW : SIDE_W;

  logic [CW-1:0]       pending_r, pending_nxt;
  logic [AW-1:0]       ws_r, ws_nxt;
  logic [PW-1:0]       erow_r, erow_nxt;
  logic [PW-1:0]       ecol_r, ecol_nxt;
  logic [SAMPLE_W-1:0] last_r, last_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  stc_ctl_t            s1_ctl_r, s1_ctl_nxt;

  logic [XW-1:0] side_x;
  logic [PW-1:0] n;
  logic [CW-1:0] n_c, n1_c, target, age_b;
  logic          drain, emit, interior;
  logic [PW:0]   col_inc, row_inc;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] ws,
                                            input logic [CW-1:0] age);
    logic [IW-1:0] w;
    logic [IW-1:0] a;
    logic [IW-1:0] d;
    w = IW'(ws);
    a = IW'(age);
    if (w >= a) d = w - a;
    else d = w + IW'(DEPTH) - a;
    return AW'(d);
  endfunction

  always_comb begin
    side_x = XW'(side_length);
    if (side_x < XW'(3)) n = PW'(3);
    else if (side_x > XW'(NMAX)) n = PW'(NMAX);
    else n = PW'(side_length);
    n_c    = CW'(n);
    n1_c   = n_c + CW'(1);
    target = pass_odd ? '0 : n1_c;
  end

  always_comb begin
    drain    = (action == ACT_DRAIN);
    emit     = drain ? (pending_r != '0) : (pending_r >= target);
    interior = (erow_r >= PW'(1)) && (erow_r <= n - PW'(2)) &&
               (ecol_r >= PW'(1)) && (ecol_r <= n - PW'(2));
    age_b    = (pending_r == '0) ? n1_c : pending_r;
    raddr_a  = slot_of(ws_r, n_c);
    raddr_b  = slot_of(ws_r, age_b);

    col_inc = {1'b0, ecol_r} + (PW+1)'(1);
    row_inc = {1'b0, erow_r} + (PW+1)'(1);

    mem_we    = accept && !drain;
    mem_waddr = ws_r;
    mem_wdata = sample;

    pending_nxt = pending_r;
    ws_nxt      = ws_r;
    erow_nxt    = erow_r;
    ecol_nxt    = ecol_r;
    last_nxt    = last_r;

    s1_ctl_nxt.emit       = emit;
    s1_ctl_nxt.avg        = !drain && interior && (pending_r == target);
    s1_ctl_nxt.odd        = pass_odd;
    s1_ctl_nxt.own_sample = !drain && (pending_r == '0);
    s1_ctl_nxt.sample     = sample;
    s1_ctl_nxt.last       = last_r;
    s1_ctl_nxt.row        = POS_OUT_W'(erow_r);
    s1_ctl_nxt.col        = POS_OUT_W'(ecol_r);
    s1_ctl_nxt.frame_end  = (erow_r == n - PW'(1)) && (ecol_r == n - PW'(1));

    if (accept) begin
      if (drain) begin
        if (emit) pending_nxt = pending_r - CW'(1);
      end else begin
        if (!emit) pending_nxt = pending_r + CW'(1);
        ws_nxt   = (ws_r == AW'(DEPTH - 1)) ? '0 : ws_r + AW'(1);
        last_nxt = sample;
      end
      if (emit) begin
        if (col_inc >= (PW+1)'(n)) begin
          ecol_nxt = '0;
          erow_nxt = (row_inc >= (PW+1)'(n)) ? '0 : PW'(row_inc);
        end else begin
          ecol_nxt = PW'(col_inc);
        end
      end
    end

    if (accept) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      ws_r       <= '0;
      erow_r     <= '0;
      ecol_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pending_r  <= pending_nxt;
      ws_r       <= ws_nxt;
      erow_r     <= erow_nxt;
      ecol_r     <= ecol_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    if (accept) s1_ctl_r <= s1_ctl_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_ctl   = s1_ctl_r;

endmodule

FILE: rtl/core/stc_out.sv
// Result stage: three-point sum and divide by three, or a passed sample, then output register.
// Depends on stc_pkg; takes the control word from stc_seq and line read data.
module stc_out import stc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 s1_valid,
  input  stc_ctl_t             s1_ctl,
  input  logic [SAMPLE_W-1:0]  rd_a,
  input  logic [SAMPLE_W-1:0]  rd_b,
  output logic                 out_valid,
  output logic [SAMPLE_W-1:0]  out_value,
  output logic [POS_OUT_W-1:0] out_row,
  output logic [POS_OUT_W-1:0] out_col,
  output logic                 out_last
);

  logic                 valid_r, valid_nxt;
  logic [SAMPLE_W-1:0]  value_r, value_nxt;
  logic [POS_OUT_W-1:0] row_r, col_r;
  logic                 last_r;
  logic [SUM_W-1:0]     sum;
  logic [PROD_W-1:0]    prod;

  always_comb begin
    if (s1_ctl.odd) begin
      sum = SUM_W'(s1_ctl.last) + SUM_W'(rd_a) + SUM_W'(rd_b);
    end else begin
      sum = SUM_W'(s1_ctl.sample) + SUM_W'(s1_ctl.last) + SUM_W'(rd_a);
    end
    prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
    if (s1_ctl.avg) value_nxt = prod[DIV3_SHIFT +: SAMPLE_W];
    else if (s1_ctl.own_sample) value_nxt = s1_ctl.sample;
    else value_nxt = rd_b;

    if (adv) valid_nxt = s1_valid && s1_ctl.emit;
    else valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
      row_r   <= s1_ctl.row;
      col_r   <= s1_ctl.col;
      last_r  <= s1_ctl.frame_end;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_last  = last_r;

endmodule

FILE: rtl/core/alternating_three_point_stencil_core.sv
// Alternating three-point stencil core, top level.
// Depends on stc_pkg, stc_line_mem, stc_seq and stc_out.
//
// Usage:
//   in_*  : raster-order samples of an n-by-n grid. in_tuser = 0 pushes the
//           sample in in_tdata, in_tuser = 1 drains one pending cell.
//   out_* : cells after one pass; out_tlast marks the last cell of the grid.
//   cfg_* : side_length (index 0) and pass_odd (index 1); write only while
//           the core is idle.
// One transaction per cycle on both channels while the output is not stalled. A
// result is registered by the line read and then by the output register.
// Odd passes emit one cell per push; even passes hold n+1 cells in the
// delay line and then emit one per push, or one per drain at frame end.
// The delay line keeps MAX_SIDE+1 samples in one memory with two read ports.
// Reset clears the counters and positions and sets side_length to 4096 and
// pass_odd to 1; the memory is not cleared. When out_tready is low the
// output register holds and one more transaction is taken into the read
// stage; in_tready then drops until the output drains.
module alternating_three_point_stencil_core import stc_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIDE_W-1:0]     cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                  in_tuser,   // [0] action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] value, [27:16] row, [39:28] column
  output logic                  out_tlast
);

  localparam int DEPTH = MAX_SIDE + 1;
  localparam int AW    = $clog2(MAX_SIDE + 1);

  logic [SIDE_W-1:0] side_r, side_nxt;
  logic              pass_r, pass_nxt;

  logic                 accept, adv, s1_valid;
  stc_ctl_t             s1_ctl;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, raddr_a, raddr_b;
  logic [SAMPLE_W-1:0]  mem_wdata, rd_a, rd_b;
  logic [SAMPLE_W-1:0]  value;
  logic [POS_OUT_W-1:0] row, col;

  always_comb begin
    side_nxt = side_r;
    pass_nxt = pass_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SIDE_LENGTH: side_nxt = cfg_data;
        REG_PASS_ODD:    pass_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      pass_r <= PASS_RESET;
    end else begin
      side_r <= side_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = !s1_valid || adv;
  assign accept    = in_tvalid && in_tready;

  stc_seq #(.MAX_SIDE(MAX_SIDE)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .adv         (adv),
    .action      (in_tuser),
    .sample      (in_tdata),
    .side_length (side_r),
    .pass_odd    (pass_r),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .raddr_a     (raddr_a),
    .raddr_b     (raddr_b),
    .s1_valid    (s1_valid),
    .s1_ctl      (s1_ctl)
  );

  stc_line_mem #(.DEPTH(DEPTH), .AW(AW), .DATA_W(SAMPLE_W)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  stc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .out_valid (out_tvalid),
    .out_value (value),
    .out_row   (row),
    .out_col   (col),
    .out_last  (out_tlast)
  );

  assign out_tdata = {col, row, value};

endmodule

FILE: tb/stencil_checker.sv
// Scoreboard for the alternating three-point stencil core: predicts every result cell
// from the accepted input and register transactions and compares it with the output.
// Depends on stc_pkg.
module stencil_checker import stc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIDE_W-1:0]     cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                  in_tuser,   // [0] action
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] value, [27:16] row, [39:28] column
  input  logic                  out_tlast,
  output int                    mismatch_count,
  output int                    points_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = DEF_MAX_SIDE + 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  value;
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 last;
  } stencil_point_t;

  stencil_point_t due_points[$];
  stencil_point_t got, want;

  logic [SAMPLE_W-1:0] history [LINE_DEPTH];
  int unsigned wr_slot, in_r, in_c, em_r, em_c, backlog;
  logic [SIDE_W-1:0] side_reg;
  logic odd_reg;

  function automatic int unsigned grid_n();
    int unsigned n;
    n = side_reg;
    if (n < 3) n = 3;
    if (n > DEF_MAX_SIDE) n = DEF_MAX_SIDE;
    return n;
  endfunction

  // sample pushed 'age' pushes ago
  function automatic int unsigned aged(input int unsigned age);
    return history[(wr_slot + LINE_DEPTH - age % LINE_DEPTH) % LINE_DEPTH];
  endfunction

  function automatic void step_pos(inout int unsigned r, inout int unsigned c,
                                   input int unsigned n);
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
  endfunction

  function automatic void emit_point(input int unsigned value, input int unsigned n);
    stencil_point_t p;
    p.value = 16'(value);
    p.row   = 12'(em_r);
    p.col   = 12'(em_c);
    p.last  = (em_r == n - 1) && (em_c == n - 1);
    due_points.insert(due_points.size(), p);
    step_pos(em_r, em_c, n);
  endfunction

  function automatic void apply_stencil_item(input logic act, input logic [SAMPLE_W-1:0] smp);
    int unsigned n, target, value;
    bit interior;
    n = grid_n();
    target = odd_reg ? 0 : n + 1;
    if (act == ACT_DRAIN) begin
      if (backlog != 0) begin
        emit_point(aged(backlog), n);
        backlog--;
      end
      return;
    end
    if (backlog < target) begin
      backlog++;
    end else begin
      value = (backlog == 0) ? smp : aged(backlog);
      interior = em_r >= 1 && em_r <= n - 2 && em_c >= 1 && em_c <= n - 2;
      if (interior && backlog == target) begin
        if (odd_reg) value = (aged(1) + aged(n) + aged(n + 1)) / 3;
        else value = (smp + aged(1) + aged(n)) / 3;
      end
      emit_point(value, n);
    end
    history[wr_slot] = smp;
    wr_slot = (wr_slot + 1) % LINE_DEPTH;
    step_pos(in_r, in_c, n);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) history[i] = '0;
      wr_slot = 0;
      in_r = 0;
      in_c = 0;
      em_r = 0;
      em_c = 0;
      backlog = 0;
      side_reg = SIDE_RESET;
      odd_reg = PASS_RESET;
      due_points.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SIDE_LENGTH) side_reg = cfg_data;
        else if (cfg_index == REG_PASS_ODD) odd_reg = cfg_data[0];
      end
      if (in_tvalid && in_tready) apply_stencil_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[15:0];
        got.row   = out_tdata[27:16];
        got.col   = out_tdata[39:28];
        got.last  = out_tlast;
        if (due_points.size() == 0) begin
          $display("%0t: unexpected transaction, got value %h row %0d col %0d last %b",
                   $realtime, got.value, got.row, got.col, got.last);
          mismatch_count++;
        end else begin
          want = due_points.pop_front();
          if (got !== want) begin
            $display({"%0t: expected value %h row %0d col %0d last %b, ",
                      "got value %h row %0d col %0d last %b"}, $realtime,
                     want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
            mismatch_count++;
          end
        end
      end
    end
    points_due = due_points.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the stencil core testbench: clock, reset, register setup, input stimulus
// and output back-pressure; stencil_checker does the prediction and comparison.
// Depends on stc_pkg, stencil_checker and alternating_three_point_stencil_core.
module tb import stc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SIDE_LENGTH;
  logic [SIDE_W-1:0]     cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;   // [15:0] sample
  logic                  in_tuser = ACT_PUSH; // [0] action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [15:0] value, [27:16] row, [39:28] column
  logic                  out_tlast;

  int          mismatch_count;
  int          points_due;
  int          items = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  logic [SAMPLE_W-1:0] odd_grid [9] = '{16'hFFFF, 16'hFFFF, 16'h0000,
                                        16'hFFFF, 16'h0001, 16'hFFFF,
                                        16'h0000, 16'hFFFF, 16'hFFFF};
  logic [SAMPLE_W-1:0] even_grid [9] = '{16'h0000, 16'h8000, 16'h7FFF,
                                         16'h0000, 16'h0000, 16'hFFFF,
                                         16'h5555, 16'hFFFF, 16'hFFFF};

  alternating_three_point_stencil_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  stencil_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .mismatch_count(mismatch_count), .points_due(points_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] smp);
    in_idle_pct  = (items < 520) ? 14 : (items < 1040) ? 72 : 0;
    out_idle_pct = (items < 520) ? 72 : (items < 1040) ? 14 : 0;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (points_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [SIDE_W-1:0] side, input logic odd);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIDE_LENGTH;
    cfg_data  <= side;
    @(negedge clk);
    cfg_index <= REG_PASS_ODD;
    cfg_data  <= {{(SIDE_W-1){1'b0}}, odd};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // pushes whole frames with scattered drains, then flushes whatever is left
  task automatic run_phase(input logic [SIDE_W-1:0] side, input logic odd, input int pushes);
    int n;
    n = (side < 3) ? 3 : (side > DEF_MAX_SIDE) ? DEF_MAX_SIDE : int'(side);
    write_cfg(side, odd);
    while (pushes > 0) begin
      if ($urandom_range(0, 99) < 4) begin
        send_item(ACT_DRAIN, random_sample());
        if (!odd) items++;
      end else begin
        send_item(ACT_PUSH, random_sample());
        pushes--;
        items++;
      end
      if (items >= 1200 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
    end
    repeat (odd ? 1 : n + 1) send_item(ACT_DRAIN, random_sample());
  endtask

  initial begin
    int side, pick;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: 3x3 odd pass with extreme samples, then 3x3 even pass and flush
    write_cfg(13'd3, 1'b1);
    foreach (odd_grid[i]) send_item(ACT_PUSH, odd_grid[i]);
    send_item(ACT_DRAIN, 16'hFFFF);
    write_cfg(13'd0, 1'b0);
    foreach (even_grid[i]) send_item(ACT_PUSH, even_grid[i]);
    repeat (5) send_item(ACT_DRAIN, 16'h0000);
    items += 24;

    while (items < 1250) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) side = $urandom_range(0, 2);
      else if (pick < 6) side = $urandom_range(3, 8);
      else if (pick < 9) side = $urandom_range(9, 16);
      else side = $urandom_range(17, 28);
      run_phase(13'(side), 1'($urandom_range(0, 1)),
                ((side > 12) ? 1 : $urandom_range(1, 3)) *
                ((side < 3) ? 9 : side * side));
    end

    // largest grid: the start of the first row
    side = $urandom_range(0, 1) ? DEF_MAX_SIDE : $urandom_range(DEF_MAX_SIDE + 1, SIDE_CAP);
    run_phase(13'(side), 1'b1, 256);

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (points_due != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
